>>> src/brle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the byte run-length encoder: segment
// commands passed from the front to the back, literal buffer write beats
// and literal read completion.
// ----------------------------------------------------------------------------
package brle_pkg;

	localparam int SEG_CNT_W      = 8;
	localparam int BUF_ADDR_W     = 7;
	localparam int SEG_FIFO_DEPTH = 4;
	localparam int SEG_FIFO_PTR_W = $clog2(SEG_FIFO_DEPTH);

	localparam logic [7:0] RUN_FLAG = 8'h80;

	typedef enum logic {
		SEG_LITERAL,
		SEG_RUN
	} seg_kind_t;

	typedef struct packed {
		seg_kind_t              kind;
		logic [SEG_CNT_W-1:0]   count;
		logic [7:0]             run_byte;
		logic                   bank;
		logic                   item_end;
	} seg_cmd_t;

	typedef struct packed {
		logic                   en;
		logic                   bank;
		logic [BUF_ADDR_W-1:0]  addr;
		logic [7:0]             data;
	} buf_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} lit_done_t;

endpackage

>>> src/brle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_front
// Accepts input bytes, tracks the pending literal or run, writes literal
// bytes into the double-banked buffer and issues segment commands.
// ----------------------------------------------------------------------------
module brle_front
	import brle_pkg::*;
#(
	parameter int MAX_LITERAL = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] value,
	input  logic       is_last,
	output logic       seg_valid,
	input  logic       seg_ready,
	output seg_cmd_t   seg_cmd,
	output buf_wr_t    buf_wr,
	input  lit_done_t  lit_done
);

	localparam int CW = $clog2(MAX_LITERAL + 2);
	localparam int IW = $clog2(MAX_LITERAL);
	localparam logic [CW-1:0] LIT_MAX = CW'(MAX_LITERAL);
	localparam logic [CW-1:0] RUN_MAX = CW'(MAX_LITERAL + 1);

	logic [CW-1:0] fill_q, rep_q;
	logic          in_run_q;
	logic [7:0]    prev_q;
	logic          bank_q;
	logic [1:0]    busy_q;
	logic          pend_valid_q;
	seg_cmd_t      pend_q;

	logic [CW-1:0] n_fill, n_rep, rep_inc, fill_inc;
	logic          n_run;
	logic [1:0]    busy_n;
	logic          seg_a_v, seg_b_v, lit_issue;
	seg_cmd_t      seg_a, seg_b, first_cmd;
	logic          accept, eq;

	assign in_ready = !pend_valid_q && !busy_q[bank_q] && seg_ready;
	assign accept   = in_valid && in_ready;
	assign eq       = (value == prev_q);
	assign rep_inc  = rep_q + CW'(1);
	assign fill_inc = fill_q + CW'(1);

	always_comb begin
		n_fill      = fill_q;
		n_rep       = rep_q;
		n_run       = in_run_q;
		seg_a_v     = 1'b0;
		seg_b_v     = 1'b0;
		lit_issue   = 1'b0;
		seg_a       = '0;
		seg_b       = '0;
		buf_wr      = '0;
		buf_wr.bank = bank_q;
		buf_wr.data = value;
		priority if (fill_q == '0) begin
			buf_wr.en = 1'b1;
			n_fill    = CW'(1);
			n_rep     = CW'(1);
			n_run     = 1'b0;
			if (is_last) begin
				seg_b_v    = 1'b1;
				seg_b.kind = SEG_LITERAL;
				seg_b.count = SEG_CNT_W'(1);
				lit_issue  = 1'b1;
			end
		end else if (in_run_q) begin
			if (eq) begin
				n_rep = rep_inc;
				if (rep_inc == RUN_MAX || is_last) begin
					seg_b_v        = 1'b1;
					seg_b.kind     = SEG_RUN;
					seg_b.count    = SEG_CNT_W'(rep_inc);
					seg_b.run_byte = prev_q;
				end
			end else begin
				seg_a_v        = 1'b1;
				seg_a.kind     = SEG_RUN;
				seg_a.count    = SEG_CNT_W'(rep_q);
				seg_a.run_byte = prev_q;
				buf_wr.en      = 1'b1;
				n_fill         = CW'(1);
				n_rep          = CW'(1);
				n_run          = 1'b0;
				if (is_last) begin
					seg_b_v     = 1'b1;
					seg_b.kind  = SEG_LITERAL;
					seg_b.count = SEG_CNT_W'(1);
					lit_issue   = 1'b1;
				end
			end
		end else begin
			if (eq) begin
				if (fill_q > CW'(1)) begin
					seg_a_v     = 1'b1;
					seg_a.kind  = SEG_LITERAL;
					seg_a.count = SEG_CNT_W'(fill_q - CW'(1));
					lit_issue   = 1'b1;
				end
				n_run  = 1'b1;
				n_rep  = CW'(2);
				n_fill = CW'(1);
				if (is_last) begin
					seg_b_v        = 1'b1;
					seg_b.kind     = SEG_RUN;
					seg_b.count    = SEG_CNT_W'(2);
					seg_b.run_byte = value;
				end
			end else begin
				buf_wr.en   = 1'b1;
				buf_wr.addr = BUF_ADDR_W'(fill_q[IW-1:0]);
				n_fill      = fill_inc;
				n_rep       = CW'(1);
				if (fill_inc == LIT_MAX || is_last) begin
					seg_b_v     = 1'b1;
					seg_b.kind  = SEG_LITERAL;
					seg_b.count = SEG_CNT_W'(fill_inc);
					lit_issue   = 1'b1;
				end
			end
		end
		seg_a.bank     = bank_q;
		seg_b.bank     = bank_q;
		seg_a.item_end = !seg_b_v;
		seg_b.item_end = 1'b1;
		if (seg_b_v) begin
			n_fill = '0;
			n_rep  = '0;
			n_run  = 1'b0;
		end
		buf_wr.en = buf_wr.en && accept;
	end

	always_comb begin
		busy_n = busy_q;
		if (lit_done.en) begin
			busy_n[lit_done.bank] = 1'b0;
		end
		if (accept && lit_issue) begin
			busy_n[bank_q] = 1'b1;
		end
	end

	assign first_cmd = seg_a_v ? seg_a : seg_b;
	assign seg_valid = pend_valid_q || (accept && (seg_a_v || seg_b_v));
	assign seg_cmd   = pend_valid_q ? pend_q : first_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			rep_q        <= '0;
			in_run_q     <= 1'b0;
			prev_q       <= '0;
			bank_q       <= 1'b0;
			busy_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			busy_q <= busy_n;
			if (pend_valid_q && seg_ready) begin
				pend_valid_q <= 1'b0;
			end
			if (accept) begin
				fill_q   <= n_fill;
				rep_q    <= n_rep;
				in_run_q <= n_run;
				prev_q   <= value;
				bank_q   <= bank_q ^ lit_issue;
				if (seg_a_v && seg_b_v) begin
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && seg_a_v && seg_b_v) begin
			pend_q <= seg_b;
		end
	end

endmodule

>>> src/brle_seg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_seg_fifo
// Short queue of segment commands between the front and the back.
// ----------------------------------------------------------------------------
module brle_seg_fifo
	import brle_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  seg_cmd_t push_cmd,
	output logic     pop_valid,
	input  logic     pop_ready,
	output seg_cmd_t pop_cmd
);

	seg_cmd_t                  slot_q [SEG_FIFO_DEPTH];
	logic [SEG_FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [SEG_FIFO_PTR_W:0]   count_q;
	logic                      push, pop;

	assign push_ready = (count_q != (SEG_FIFO_PTR_W + 1)'(SEG_FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + SEG_FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + SEG_FIFO_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (SEG_FIFO_PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (SEG_FIFO_PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> src/brle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_back
// Holds the literal buffer, expands segment commands into a byte stream
// one byte a cycle unless stalled, packing the bytes into output words.
// ----------------------------------------------------------------------------
module brle_back
	import brle_pkg::*;
#(
	parameter int MAX_LITERAL = 128,
	parameter int WORD_BYTES  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seg_valid,
	output logic        seg_ready,
	input  seg_cmd_t    seg_cmd,
	input  buf_wr_t     buf_wr,
	output lit_done_t   lit_done,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] packed_bytes,
	output logic [3:0]  byte_count,
	output logic        last_of_item
);

	localparam int CW = $clog2(MAX_LITERAL + 2);
	localparam int IW = $clog2(MAX_LITERAL);
	localparam int LW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

	logic [7:0] lit_mem [2][MAX_LITERAL];

	logic          gen_active_q;
	seg_cmd_t      gen_cmd_q;
	logic [CW-1:0] gen_idx_q;

	logic       byte_valid_s2, from_mem_s2, item_end_s2;
	logic [7:0] const_byte_s2, rd_data_s2;

	logic [WORD_BYTES-1:0][7:0] acc_q, merged;
	logic [LW-1:0]              acc_cnt_q;
	logic                       ov_q, out_last_q;
	logic [WORD_BYTES*8-1:0]    out_word_q;
	logic [3:0]                 out_cnt_q;

	logic          advance, emit, gen_last, rd_en, load;
	logic [CW-1:0] last_idx;
	logic [7:0]    header, gen_byte, byte_in;
	logic [IW-1:0] rd_addr;
	logic          complete, pack_take;

	assign advance  = !byte_valid_s2 || pack_take;
	assign emit     = gen_active_q && advance;
	assign last_idx = (gen_cmd_q.kind == SEG_RUN) ? CW'(1) : gen_cmd_q.count[CW-1:0];
	assign gen_last = (gen_idx_q == last_idx);
	assign load     = !gen_active_q || (emit && gen_last);
	assign seg_ready = load;
	assign rd_addr  = IW'(gen_idx_q - CW'(1));

	always_comb begin
		if (gen_cmd_q.kind == SEG_RUN) begin
			header = RUN_FLAG | {1'b0, 7'(gen_cmd_q.count - SEG_CNT_W'(2))};
		end else begin
			header = 8'(gen_cmd_q.count - SEG_CNT_W'(1));
		end
		gen_byte = (gen_idx_q == '0) ? header : gen_cmd_q.run_byte;
		rd_en    = emit && (gen_idx_q != '0) && (gen_cmd_q.kind == SEG_LITERAL);
	end

	assign lit_done.en   = emit && gen_last && (gen_cmd_q.kind == SEG_LITERAL);
	assign lit_done.bank = gen_cmd_q.bank;

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			lit_mem[buf_wr.bank][buf_wr.addr[IW-1:0]] <= buf_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s2 <= lit_mem[gen_cmd_q.bank][rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_active_q  <= 1'b0;
			gen_idx_q     <= '0;
			byte_valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				byte_valid_s2 <= gen_active_q;
			end
			if (load) begin
				gen_active_q <= seg_valid;
				gen_idx_q    <= '0;
			end else if (emit) begin
				gen_idx_q <= gen_idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && seg_valid) begin
			gen_cmd_q <= seg_cmd;
		end
		if (emit) begin
			from_mem_s2   <= rd_en;
			const_byte_s2 <= gen_byte;
			item_end_s2   <= gen_last && gen_cmd_q.item_end;
		end
	end

	assign byte_in   = from_mem_s2 ? rd_data_s2 : const_byte_s2;
	assign complete  = (acc_cnt_q == LW'(WORD_BYTES - 1)) || item_end_s2;
	assign pack_take = byte_valid_s2 && (!complete || !ov_q || out_ready);

	always_comb begin
		for (int i = 0; i < WORD_BYTES; i++) begin
			merged[i] = (LW'(i) == acc_cnt_q) ? byte_in : acc_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			acc_cnt_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (pack_take && complete) begin
				acc_q     <= '0;
				acc_cnt_q <= '0;
				ov_q      <= 1'b1;
			end else begin
				if (pack_take) begin
					acc_q     <= merged;
					acc_cnt_q <= acc_cnt_q + LW'(1);
				end
				if (ov_q && out_ready) begin
					ov_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pack_take && complete) begin
			out_word_q <= merged;
			out_cnt_q  <= 4'(acc_cnt_q) + 4'd1;
			out_last_q <= item_end_s2;
		end
	end

	assign out_valid    = ov_q;
	assign packed_bytes = 64'(out_word_q);
	assign byte_count   = out_cnt_q;
	assign last_of_item = out_last_q;

endmodule

>>> src/byte_run_length_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_length_encoder
// Run-length encoder for a byte stream: run and literal segments packed
// into output words of up to WORD_BYTES bytes.
// ----------------------------------------------------------------------------
// The front takes one byte a cycle unless stalled. An item that completes
// two segments at once (a run or literal closed by the final byte of the
// stream) holds the input while its second segment enters the queue.
// Literal bytes live in a two-bank buffer; the back reads it one byte a
// cycle through a registered read port and emits one encoded byte a cycle
// unless the output stalls it. The input stalls while the bank in use still
// holds a literal waiting to be read, or while the segment queue is full.
// A completed segment passes the queue and the command, byte and output
// registers before out_valid rises.
// ----------------------------------------------------------------------------
module byte_run_length_encoder
	import brle_pkg::*;
#(
	parameter int MAX_LITERAL = 128,
	parameter int WORD_BYTES  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  value,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] packed_bytes,
	output logic [3:0]  byte_count,
	output logic        last_of_item
);

	logic      push_valid, push_ready, pop_valid, pop_ready;
	seg_cmd_t  push_cmd, pop_cmd;
	buf_wr_t   buf_wr;
	lit_done_t lit_done;

	brle_front #(
		.MAX_LITERAL(MAX_LITERAL)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.is_last  (is_last),
		.seg_valid(push_valid),
		.seg_ready(push_ready),
		.seg_cmd  (push_cmd),
		.buf_wr   (buf_wr),
		.lit_done (lit_done)
	);

	brle_seg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	brle_back #(
		.MAX_LITERAL(MAX_LITERAL),
		.WORD_BYTES (WORD_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.seg_valid   (pop_valid),
		.seg_ready   (pop_ready),
		.seg_cmd     (pop_cmd),
		.buf_wr      (buf_wr),
		.lit_done    (lit_done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_bytes(packed_bytes),
		.byte_count  (byte_count),
		.last_of_item(last_of_item)
	);

	a_bank_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_wr.en && lit_done.en) |-> (buf_wr.bank != lit_done.bank))
		else $error("literal buffer written in a bank still being read");

	a_short_word_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (byte_count != 4'(WORD_BYTES))) |-> last_of_item)
		else $error("partial output word without end of item");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((byte_count != 4'd0) && (byte_count <= 4'(WORD_BYTES))))
		else $error("output byte count out of range");

endmodule
